### sv/rsc_pkg.sv
// Shared codes and fixed widths for the ramp stream checker.
// No dependencies; the files that use this package refer to it by scoped names.
package rsc_pkg;

   localparam int EVENT_BITS = 3;
   localparam int KIND_BITS  = 2;
   localparam int CSR_BITS   = 8;

   // Event codes on the result channel
   localparam logic [EVENT_BITS-1:0] EV_NONE      = 3'd0;
   localparam logic [EVENT_BITS-1:0] EV_NO_SILENCE = 3'd1;
   localparam logic [EVENT_BITS-1:0] EV_SIGNAL    = 3'd2;
   localparam logic [EVENT_BITS-1:0] EV_RUN_FOUND = 3'd3;
   localparam logic [EVENT_BITS-1:0] EV_RUN_ENDED = 3'd4;

   // Error classes reported with a run-ended event
   localparam logic [KIND_BITS-1:0] ERR_NONE     = 2'd0;
   localparam logic [KIND_BITS-1:0] ERR_REPEATED = 2'd1;
   localparam logic [KIND_BITS-1:0] ERR_SKIPPED  = 2'd2;
   localparam logic [KIND_BITS-1:0] ERR_WRONG    = 2'd3;

   localparam logic [CSR_BITS-1:0] RUN_THRESHOLD_RESET = 8'd2;

endpackage

### sv/rsc_req_if.sv
// Sample channel of the ramp stream checker: valid/ready plus one sample.
// Depends on nothing but its width parameter.
interface rsc_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### sv/rsc_rsp_if.sv
// Result channel of the ramp stream checker: valid/ready plus event and counters.
// Depends on rsc_pkg for the event and error code widths.
interface rsc_rsp_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 32
);
   logic                            valid;
   logic                            ready;
   logic [rsc_pkg::EVENT_BITS-1:0]  event_res;
   logic [COUNT_BITS-1:0]           event_position;
   logic [COUNT_BITS-1:0]           silent_samples;
   logic [COUNT_BITS-1:0]           run_length;
   logic [SAMPLE_BITS-1:0]          expected_value;
   logic [rsc_pkg::KIND_BITS-1:0]   error_kind;
   logic [COUNT_BITS-1:0]           error_total;
   logic [COUNT_BITS-1:0]           skipped_total;
   logic [COUNT_BITS-1:0]           repeated_total;
   logic [COUNT_BITS-1:0]           wrong_total;

   modport source (
      output valid, output event_res, output event_position, output silent_samples,
      output run_length, output expected_value, output error_kind, output error_total,
      output skipped_total, output repeated_total, output wrong_total,
      input  ready
   );
   modport sink (
      input valid, input event_res, input event_position, input silent_samples,
      input run_length, input expected_value, input error_kind, input error_total,
      input skipped_total, input repeated_total, input wrong_total,
      output ready
   );
endinterface

### sv/ramp_stream_checker_top.sv
// Ramp stream checker: flags leading silence, signal start, ramp runs and breaks.
// Ramp stream checker top level. Depends on rsc_pkg, rsc_req_if, rsc_rsp_if,
// rsc_in_stage and rsc_core.
// Usage:
//   req_chan carries one sample per beat; rsp_chan returns exactly one result
//   beat per sample, in order, with the event code, its position, the silent
//   count, the ended run length, the expected value, the error class and the
//   four saturating error totals after that sample.
//   csr_wr_en/csr_wr_data write run_threshold; write it only while idle.
// Timing:
//   An accepted sample lands in the input register; its result is then
//   registered in the result register, which drives rsp_chan.valid.
//   One sample per cycle is sustained while rsp_chan.ready is high; the input
//   and result registers each hold one beat, the state update between them.
// Reset:
//   Synchronous reset returns the checker to its start mode, clears all
//   counters and sets run_threshold to 2.
// Stalls:
//   While rsp_chan.ready is low the result holds; one more sample is still
//   taken into the input register, after which req_chan.ready drops.
module ramp_stream_checker_top #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   rsc_req_if.sink                      req_chan,
   rsc_rsp_if.source                    rsp_chan,
   input  logic                         csr_wr_en,
   input  logic [rsc_pkg::CSR_BITS-1:0] csr_wr_data
);

   logic                   stage_valid;
   logic [SAMPLE_BITS-1:0] stage_sample;
   logic                   take;

   rsc_in_stage #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .take         (take),
      .stage_valid  (stage_valid),
      .stage_sample (stage_sample)
   );

   rsc_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .stage_valid  (stage_valid),
      .stage_sample (stage_sample),
      .take         (take),
      .rsp_chan     (rsp_chan)
   );

endmodule

### sv/rsc_in_stage.sv
// Input register of the ramp stream checker: captures one sample beat.
// Depends on rsc_req_if.
module rsc_in_stage #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   rsc_req_if.sink                req_chan,
   input  logic                   take,
   output logic                   stage_valid,
   output logic [SAMPLE_BITS-1:0] stage_sample
);

   logic                   valid_ff;
   logic                   valid_in;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic                   load;

   // free the register whenever the core consumes it this cycle
   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= req_chan.sample;
      end
   end

   assign stage_valid  = valid_ff;
   assign stage_sample = sample_ff;

endmodule

### sv/rsc_core.sv
// Checker state, single-pass next-state/result logic and the result register.
// Depends on rsc_pkg and rsc_rsp_if.
module rsc_core #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [rsc_pkg::CSR_BITS-1:0]  csr_wr_data,
   input  logic                          stage_valid,
   input  logic [SAMPLE_BITS-1:0]        stage_sample,
   output logic                          take,
   rsc_rsp_if.source                     rsp_chan
);

   typedef enum logic [1:0] {
      MODE_START   = 2'd0,
      MODE_SILENCE = 2'd1,
      MODE_SEARCH  = 2'd2,
      MODE_RUN     = 2'd3
   } mode_type;

   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_ONE;
   endfunction

   // checker state
   mode_type                     mode_ff, mode_in;
   logic [SAMPLE_BITS-1:0]       prev_ff;
   logic [COUNT_BITS-1:0]        index_ff, index_in;
   logic [COUNT_BITS-1:0]        silence_ff, silence_in;
   logic [COUNT_BITS-1:0]        run_ff, run_in;
   logic [COUNT_BITS-1:0]        err_all_ff, err_all_in;
   logic [COUNT_BITS-1:0]        err_skip_ff, err_skip_in;
   logic [COUNT_BITS-1:0]        err_rep_ff, err_rep_in;
   logic [COUNT_BITS-1:0]        err_wrong_ff, err_wrong_in;
   logic [rsc_pkg::CSR_BITS-1:0] threshold_ff;

   // result register
   logic                           out_valid_ff, out_valid_in;
   logic [rsc_pkg::EVENT_BITS-1:0] out_event_ff, out_event_in;
   logic [COUNT_BITS-1:0]          out_pos_ff, out_pos_in;
   logic [COUNT_BITS-1:0]          out_silent_ff, out_silent_in;
   logic [COUNT_BITS-1:0]          out_runlen_ff, out_runlen_in;
   logic [SAMPLE_BITS-1:0]         out_expected_ff, out_expected_in;
   logic [rsc_pkg::KIND_BITS-1:0]  out_kind_ff, out_kind_in;

   logic [SAMPLE_BITS-1:0] expected;
   logic [COUNT_BITS-1:0]  run_inc;
   logic [COUNT_BITS-1:0]  thr_ext;
   logic                   is_zero;
   logic                   is_match;
   logic                   is_skip;

   // the result register loads a staged sample's result whenever it is empty or being drained
   assign take = stage_valid && (!out_valid_ff || rsp_chan.ready);

   assign expected = prev_ff + SAMPLE_BITS'(1);
   assign run_inc  = sat_inc(run_ff);
   assign thr_ext  = COUNT_BITS'(threshold_ff);
   assign is_zero  = (stage_sample == '0);
   assign is_match = (stage_sample == expected);
   // compare against previous plus one without wrapping
   assign is_skip  = {1'b0, stage_sample} > ({1'b0, prev_ff} + (SAMPLE_BITS + 1)'(1));

   always_comb begin
      mode_in      = mode_ff;
      index_in     = index_ff + CNT_ONE;
      silence_in   = silence_ff;
      run_in       = run_ff;
      err_all_in   = err_all_ff;
      err_skip_in  = err_skip_ff;
      err_rep_in   = err_rep_ff;
      err_wrong_in = err_wrong_ff;
      out_event_in    = rsc_pkg::EV_NONE;
      out_pos_in      = '0;
      out_silent_in   = '0;
      out_runlen_in   = '0;
      out_expected_in = expected;
      out_kind_in     = rsc_pkg::ERR_NONE;

      unique case (mode_ff)
         MODE_START: begin
            if (!is_zero) begin
               out_event_in = rsc_pkg::EV_NO_SILENCE;
               out_pos_in   = index_ff;
               mode_in      = MODE_SEARCH;
            end else begin
               mode_in    = MODE_SILENCE;
               silence_in = CNT_ONE;
            end
         end
         MODE_SILENCE: begin
            if (stage_sample == SAMPLE_BITS'(1)) begin
               // the last zero counts as the ramp's first value
               out_event_in  = rsc_pkg::EV_SIGNAL;
               out_pos_in    = index_ff - CNT_ONE;
               out_silent_in = (silence_ff == '0) ? '0 : silence_ff - CNT_ONE;
               mode_in       = MODE_SEARCH;
            end else if (!is_zero) begin
               out_event_in  = rsc_pkg::EV_SIGNAL;
               out_pos_in    = index_ff;
               out_silent_in = silence_ff;
               mode_in       = MODE_SEARCH;
            end else begin
               silence_in = sat_inc(silence_ff);
            end
         end
         MODE_SEARCH: begin
            if (!is_match) begin
               run_in = '0;
            end else begin
               run_in = run_inc;
               if (run_inc > thr_ext) begin
                  mode_in      = MODE_RUN;
                  out_event_in = rsc_pkg::EV_RUN_FOUND;
                  out_pos_in   = index_in - thr_ext;
               end
            end
         end
         MODE_RUN: begin
            if (is_match) begin
               run_in = run_inc;
            end else begin
               out_event_in  = rsc_pkg::EV_RUN_ENDED;
               out_pos_in    = index_in;
               out_runlen_in = run_ff;
               err_all_in    = sat_inc(err_all_ff);
               priority if (stage_sample == prev_ff) begin
                  out_kind_in = rsc_pkg::ERR_REPEATED;
                  err_rep_in  = sat_inc(err_rep_ff);
               end else if (is_skip) begin
                  out_kind_in = rsc_pkg::ERR_SKIPPED;
                  err_skip_in = sat_inc(err_skip_ff);
               end else begin
                  out_kind_in  = rsc_pkg::ERR_WRONG;
                  err_wrong_in = sat_inc(err_wrong_ff);
               end
               run_in  = '0;
               mode_in = MODE_SEARCH;
            end
         end
         default: begin
            mode_in = MODE_START;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (take) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_START;
         prev_ff      <= '0;
         index_ff     <= '0;
         silence_ff   <= '0;
         run_ff       <= '0;
         err_all_ff   <= '0;
         err_skip_ff  <= '0;
         err_rep_ff   <= '0;
         err_wrong_ff <= '0;
         threshold_ff <= rsc_pkg::RUN_THRESHOLD_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
         if (take) begin
            mode_ff      <= mode_in;
            prev_ff      <= stage_sample;
            index_ff     <= index_in;
            silence_ff   <= silence_in;
            run_ff       <= run_in;
            err_all_ff   <= err_all_in;
            err_skip_ff  <= err_skip_in;
            err_rep_ff   <= err_rep_in;
            err_wrong_ff <= err_wrong_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_event_ff    <= out_event_in;
         out_pos_ff      <= out_pos_in;
         out_silent_ff   <= out_silent_in;
         out_runlen_ff   <= out_runlen_in;
         out_expected_ff <= out_expected_in;
         out_kind_ff     <= out_kind_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.event_res      = out_event_ff;
   assign rsp_chan.event_position = out_pos_ff;
   assign rsp_chan.silent_samples = out_silent_ff;
   assign rsp_chan.run_length     = out_runlen_ff;
   assign rsp_chan.expected_value = out_expected_ff;
   assign rsp_chan.error_kind     = out_kind_ff;
   // counters come from the state registers, which hold the state after the presented beat's update
   assign rsp_chan.error_total    = err_all_ff;
   assign rsp_chan.skipped_total  = err_skip_ff;
   assign rsp_chan.repeated_total = err_rep_ff;
   assign rsp_chan.wrong_total    = err_wrong_ff;

   a_kind_with_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_kind_ff != rsc_pkg::ERR_NONE)
      |-> (out_event_ff == rsc_pkg::EV_RUN_ENDED))
      else $error("error kind reported without run-ended event");

   a_end_has_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_event_ff == rsc_pkg::EV_RUN_ENDED)
      |-> (out_kind_ff != rsc_pkg::ERR_NONE))
      else $error("run-ended event without error kind");

   a_run_entry: assert property (@(posedge clock) disable iff (reset)
      $past(take) && !$past(reset) && (mode_ff == MODE_RUN) && ($past(mode_ff) != MODE_RUN)
      |-> (out_event_ff == rsc_pkg::EV_RUN_FOUND))
      else $error("run mode entered without run-found event");

   a_err_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (err_all_ff >= $past(err_all_ff)))
      else $error("error total decreased");

   a_err_only_on_take: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(take) |-> $stable(err_all_ff) && $stable(index_ff))
      else $error("checker state moved without a beat");

endmodule

### sim/ramp_stream_checker_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for ramp_stream_checker_top: drives sample beats, predicts each
// result beat in-line and compares every field. Depends on rsc_pkg, rsc_req_if, rsc_rsp_if.
module ramp_stream_checker_top_test;

   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 32;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      TRK_START,
      TRK_SILENCE,
      TRK_SEARCH,
      TRK_RUN
   } tracker_mode_type;

   typedef struct packed {
      logic [rsc_pkg::EVENT_BITS-1:0] event_res;
      logic [COUNT_BITS-1:0]          event_position;
      logic [COUNT_BITS-1:0]          silent_samples;
      logic [COUNT_BITS-1:0]          run_length;
      logic [SAMPLE_BITS-1:0]         expected_value;
      logic [rsc_pkg::KIND_BITS-1:0]  error_kind;
      logic [COUNT_BITS-1:0]          error_total;
      logic [COUNT_BITS-1:0]          skipped_total;
      logic [COUNT_BITS-1:0]          repeated_total;
      logic [COUNT_BITS-1:0]          wrong_total;
   } ramp_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [rsc_pkg::CSR_BITS-1:0] csr_wr_data = '0;

   rsc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   rsc_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) rsp_chan ();

   ramp_stream_checker_top #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // Predicted checker state
   tracker_mode_type             tracker_mode = TRK_START;
   logic [SAMPLE_BITS-1:0]       prior_sample = '0;
   logic [COUNT_BITS-1:0]        sample_count = '0;
   logic [COUNT_BITS-1:0]        silent_count = '0;
   logic [COUNT_BITS-1:0]        match_count = '0;
   logic [COUNT_BITS-1:0]        errs_all = '0;
   logic [COUNT_BITS-1:0]        errs_skipped = '0;
   logic [COUNT_BITS-1:0]        errs_repeated = '0;
   logic [COUNT_BITS-1:0]        errs_wrong = '0;
   logic [rsc_pkg::CSR_BITS-1:0] run_threshold_model = rsc_pkg::RUN_THRESHOLD_RESET;

   ramp_result_type pending_results[$];
   int              mismatch_count = 0;
   bit              req_gaps_on = 1'b1;
   bit              rsp_stalls_on = 1'b1;

   function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic ramp_result_type predict_ramp_step(logic [SAMPLE_BITS-1:0] s);
      ramp_result_type        r;
      logic [SAMPLE_BITS-1:0] last;
      last = prior_sample;
      r = '0;
      r.expected_value = last + 1'b1;
      sample_count = sample_count + 1'b1;
      case (tracker_mode)
         TRK_START: begin
            if (s != '0) begin
               r.event_res = rsc_pkg::EV_NO_SILENCE;
               r.event_position = sample_count - 1'b1;
               tracker_mode = TRK_SEARCH;
            end else begin
               tracker_mode = TRK_SILENCE;
               silent_count = COUNT_BITS'(1);
            end
         end
         TRK_SILENCE: begin
            if (s == SAMPLE_BITS'(1)) begin
               // the last zero counts as the first ramp step
               r.event_res = rsc_pkg::EV_SIGNAL;
               r.event_position = sample_count - COUNT_BITS'(2);
               r.silent_samples = (silent_count == '0) ? '0 : silent_count - 1'b1;
               tracker_mode = TRK_SEARCH;
            end else if (s != '0) begin
               r.event_res = rsc_pkg::EV_SIGNAL;
               r.event_position = sample_count - 1'b1;
               r.silent_samples = silent_count;
               tracker_mode = TRK_SEARCH;
            end else begin
               silent_count = sat_inc(silent_count);
            end
         end
         TRK_SEARCH: begin
            if (s != r.expected_value) begin
               match_count = '0;
            end else begin
               match_count = sat_inc(match_count);
               if (match_count > COUNT_BITS'(run_threshold_model)) begin
                  tracker_mode = TRK_RUN;
                  r.event_res = rsc_pkg::EV_RUN_FOUND;
                  r.event_position = sample_count - COUNT_BITS'(run_threshold_model);
               end
            end
         end
         default: begin
            if (s == r.expected_value) begin
               match_count = sat_inc(match_count);
            end else begin
               r.event_res = rsc_pkg::EV_RUN_ENDED;
               r.event_position = sample_count;
               r.run_length = match_count;
               errs_all = sat_inc(errs_all);
               if (s == last) begin
                  r.error_kind = rsc_pkg::ERR_REPEATED;
                  errs_repeated = sat_inc(errs_repeated);
               end else if ({1'b0, s} > {1'b0, last} + 1'b1) begin
                  r.error_kind = rsc_pkg::ERR_SKIPPED;
                  errs_skipped = sat_inc(errs_skipped);
               end else begin
                  r.error_kind = rsc_pkg::ERR_WRONG;
                  errs_wrong = sat_inc(errs_wrong);
               end
               match_count = '0;
               tracker_mode = TRK_SEARCH;
            end
         end
      endcase
      prior_sample = s;
      r.error_total = errs_all;
      r.skipped_total = errs_skipped;
      r.repeated_total = errs_repeated;
      r.wrong_total = errs_wrong;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 50)
         $display("MISMATCH @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [COUNT_BITS-1:0] got,
                              input logic [COUNT_BITS-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   // Send one sample beat after a random gap when req_gaps_on is set; predict once it is taken.
   task automatic push_sample(input logic [SAMPLE_BITS-1:0] value);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.sample <= value;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_results.push_back(predict_ramp_step(value));
   endtask

   task automatic send_ramp(input logic [SAMPLE_BITS-1:0] first, input int len,
                            output logic [SAMPLE_BITS-1:0] last);
      last = first;
      for (int i = 0; i < len; i++) begin
         last = first + SAMPLE_BITS'(i);
         push_sample(last);
      end
   endtask

   // Hold the sender until every pending result beat is back or the wait times out.
   task automatic settle_pipeline;
      int waited;
      req_chan.valid <= 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic set_run_threshold(input logic [rsc_pkg::CSR_BITS-1:0] value);
      settle_pipeline();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      run_threshold_model = value;
   endtask

   // Only one opening can happen per reset; the seed picks which.
   task automatic test_leading_silence;
      case ($urandom_range(0, 2))
         0: push_sample(16'hFFFF);
         1: begin
            repeat (3) push_sample(16'h0000);
            push_sample(16'h0001);
         end
         default: begin
            repeat (2) push_sample(16'h0000);
            push_sample(16'h8000);
         end
      endcase
   endtask

   task automatic test_run_breaks;
      logic [SAMPLE_BITS-1:0] last;
      send_ramp(16'd100, 4, last);
      push_sample(last);                 // repeated value
      send_ramp(16'hFFFE, 4, last);      // ramp through the wrap
      push_sample(16'd9);                // skipped values
      send_ramp(16'd200, 4, last);
      push_sample(16'd3);                // wrong value
      send_ramp(16'hFFFC, 4, last);
      push_sample(16'd7);                // wrong value right at the top
   endtask

   task automatic test_threshold_extremes;
      logic [SAMPLE_BITS-1:0] last;
      set_run_threshold(8'd0);
      send_ramp(16'd500, 4, last);
      push_sample(last);
      set_run_threshold(8'd255);
      send_ramp(16'($urandom), 258, last);
      push_sample(last);
   endtask

   task automatic test_random_stream;
      int                     sent;
      int                     len;
      int                     pick;
      logic [SAMPLE_BITS-1:0] first;
      logic [SAMPLE_BITS-1:0] last;
      logic [SAMPLE_BITS-1:0] v;
      sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_run_threshold(8'($urandom_range(0, 3)));
            1: set_run_threshold(8'd1);
            2: set_run_threshold(8'($urandom_range(4, 12)));
            default: set_run_threshold(8'($urandom_range(0, 12)));
         endcase
         while (sent < (phase + 1) * 500) begin
            req_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 8) begin
               first = ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 15))
                                                  : 16'($urandom);
               if ($urandom_range(0, 3) != 0)
                  len = int'(run_threshold_model) + 2 + $urandom_range(0, 8);
               else
                  len = $urandom_range(1, int'(run_threshold_model) + 1);
               send_ramp(first, len, last);
               pick = $urandom_range(0, 2);
               if (pick == 0)
                  v = last;
               else if ((pick == 1 || last == 16'h0000) && last < 16'hFFFE)
                  v = last + 16'd2 + 16'($urandom_range(0, 65533 - last));
               else if (last == 16'hFFFF)
                  v = 16'($urandom_range(1, 65534));
               else
                  v = 16'($urandom_range(0, last - 1));
               push_sample(v);
               sent += len + 1;
            end else begin
               len = $urandom_range(1, 6);
               repeat (len) push_sample(16'($urandom));
               sent += len;
            end
         end
      end
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // Result side: random stall before each beat while rsp_stalls_on is set.
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = rsp_stalls_on ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      ramp_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with nothing pending");
         end else begin
            want = pending_results.pop_front();
            check_field("event_res", rsp_chan.event_res, want.event_res);
            check_field("event_position", rsp_chan.event_position, want.event_position);
            check_field("silent_samples", rsp_chan.silent_samples, want.silent_samples);
            check_field("run_length", rsp_chan.run_length, want.run_length);
            check_field("expected_value", rsp_chan.expected_value, want.expected_value);
            check_field("error_kind", rsp_chan.error_kind, want.error_kind);
            check_field("error_total", rsp_chan.error_total, want.error_total);
            check_field("skipped_total", rsp_chan.skipped_total, want.skipped_total);
            check_field("repeated_total", rsp_chan.repeated_total, want.repeated_total);
            check_field("wrong_total", rsp_chan.wrong_total, want.wrong_total);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("ramp_stream_checker_top test failed");
      $finish;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.sample = '0;
      rsp_chan.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_leading_silence();
      test_run_breaks();
      test_threshold_extremes();
      test_random_stream();
      settle_pipeline();
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d result beats never arrived", pending_results.size()));
      if (mismatch_count == 0)
         $display("ramp_stream_checker_top test passed");
      else
         $display("ramp_stream_checker_top test failed");
      $finish;
   end

endmodule

### ramp_stream_checker_top.f
sv/rsc_pkg.sv
sv/rsc_req_if.sv
sv/rsc_rsp_if.sv
sv/rsc_in_stage.sv
sv/rsc_core.sv
sv/ramp_stream_checker_top.sv
sim/ramp_stream_checker_top_test.sv
